// ===== rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg: GF(256) arithmetic and codes for the RS(8,6) codec
// Field helpers, elaboration-time tables and encoder constants shared by the
// syndrome unit and the codec pipeline.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int          NUM_BYTES = 8;
  localparam int          NUM_INFO  = 6;
  localparam logic [7:0]  GF_RED    = 8'h1D;
  localparam logic [7:0]  GF_TOP    = 8'h80;
  localparam logic [7:0]  GF_ALPHA  = 8'h02;
  localparam int          GF_ORDER  = 255;

  typedef logic [7:0] gf_t;
  typedef gf_t gf_tab_t [256];

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAN = 2'd0,
    ST_FIXED = 2'd1,
    ST_FAIL  = 2'd2
  } status_t;

  // Shift-and-add product; with a constant operand it folds to an XOR network.
  function automatic gf_t gf_mul(input gf_t x, input gf_t y);
    gf_t acc;
    gf_t a;
    gf_t b;
    acc = '0;
    a   = x;
    b   = y;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) acc = acc ^ a;
      if ((a & GF_TOP) != 8'h00) a = (a << 1) ^ GF_RED;
      else a = a << 1;
      b = b >> 1;
    end
    return acc;
  endfunction

  // Powers of alpha; entry 255 repeats entry 0 so every index is defined.
  function automatic gf_tab_t gf_exp_table();
    gf_tab_t t;
    gf_t     v;
    v = 8'h01;
    for (int k = 0; k < 256; k++) begin
      t[k] = v;
      v = gf_mul(v, GF_ALPHA);
    end
    return t;
  endfunction

  // Discrete log; the entry for zero is never used and reads as zero.
  function automatic gf_tab_t gf_log_table();
    gf_tab_t t;
    gf_t     v;
    for (int k = 0; k < 256; k++) t[k] = 8'h00;
    v = 8'h01;
    for (int k = 0; k < GF_ORDER; k++) begin
      t[v] = 8'(k);
      v = gf_mul(v, GF_ALPHA);
    end
    return t;
  endfunction

  function automatic gf_t gf_inv(input gf_t x);
    gf_t r;
    r = 8'h00;
    for (int k = 1; k < 256; k++) begin
      if (gf_mul(x, 8'(k)) == 8'h01) r = 8'(k);
    end
    return r;
  endfunction

  localparam gf_tab_t GF_EXP = gf_exp_table();
  localparam gf_tab_t GF_LOG = gf_log_table();

  // Parity bytes solve a 2x2 system in the two partial syndromes.
  localparam gf_t ENC_DET  = gf_mul(GF_EXP[6], GF_EXP[14]) ^ gf_mul(GF_EXP[7], GF_EXP[12]);
  localparam gf_t ENC_IDET = gf_inv(ENC_DET);
  localparam gf_t P6_S0    = gf_mul(GF_EXP[14], ENC_IDET);
  localparam gf_t P6_S1    = gf_mul(GF_EXP[7], ENC_IDET);
  localparam gf_t P7_S0    = gf_mul(GF_EXP[12], ENC_IDET);
  localparam gf_t P7_S1    = gf_mul(GF_EXP[6], ENC_IDET);

endpackage

// ===== rtl/rsc_syndrome.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_syndrome: syndrome evaluation for the RS(8,6) codec
// Evaluates the word polynomial at alpha and alpha^2 with constant multipliers.
// ----------------------------------------------------------------------------
module rsc_syndrome
  import rsc_pkg::*;
(
  input  logic [63:0] word,
  output gf_t         syn0,
  output gf_t         syn1
);

  always_comb begin
    syn0 = '0;
    syn1 = '0;
    for (int i = 0; i < NUM_BYTES; i++) begin
      syn0 = syn0 ^ gf_mul(word[8*i +: 8], GF_EXP[8'(i)]);
      syn1 = syn1 ^ gf_mul(word[8*i +: 8], GF_EXP[8'(2*i)]);
    end
  end

endmodule

// ===== rtl/rs_8_6_gf256_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs_8_6_gf256_codec: RS(8,6) encoder and single-byte corrector over GF(256)
// A word is taken at every rising edge where start is high and busy is low;
// in_opcode picks encode (parity into bytes 6 and 7) or decode and correct.
// busy is high only while rst_n is low, so one word can enter every cycle.
// Four register stages: syndromes, log lookup plus parity, error locator,
// output register. The result passes through these stages in order and
// stays on out_codeword_out and out_status for one cycle, marked by out_valid.
// Throughput is one word per cycle; the depth is set by the syndrome
// XOR trees, the 256-entry log tables and the locator subtract and select.
// out_status is 0 for a clean or encoded word, 1 when one byte was fixed and
// 2 when the word cannot be corrected, which then passes through unchanged.
// The receiver cannot hold results off, so the pipeline never stalls.
// A synchronous reset clears every stage valid bit; words in flight are lost.
// The block keeps no state between words.
// ----------------------------------------------------------------------------
module rs_8_6_gf256_codec
  import rsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [63:0] in_data_word,
  output logic        out_valid,
  output logic [63:0] out_codeword_out,
  output logic [1:0]  out_status
);

  logic        accept;
  logic [63:0] word_in;
  gf_t         syn0;
  gf_t         syn1;

  // Stage 1: syndromes
  logic        v1_r, v1_nxt;
  opcode_t     op1_r;
  logic [63:0] word1_r;
  gf_t         syn0_1_r;
  gf_t         syn1_1_r;

  // Stage 2: logs and parity
  logic        v2_r;
  opcode_t     op2_r;
  logic [63:0] word2_r, word2_nxt;
  gf_t         syn0_2_r;
  gf_t         log0_r;
  gf_t         log1_r;
  logic        zero0_r;
  logic        zero1_r;

  // Stage 3: locator
  logic        v3_r;
  opcode_t     op3_r;
  logic [63:0] word3_r;
  status_t     status3_r, status3_nxt;
  gf_t         err3_r, err3_nxt;
  logic [2:0]  pos3_r;
  logic [8:0]  diff;
  logic [8:0]  err_pos;

  // Stage 4: output
  logic        out_valid_r;
  logic [63:0] out_word_r, out_word_nxt;
  status_t     out_status_r;

  assign busy    = ~rst_n;
  assign accept  = start & ~busy;
  assign v1_nxt  = accept;
  // Encode ignores the incoming bytes 6 and 7.
  assign word_in = (opcode_t'(in_opcode) == OP_ENC) ?
                   {16'h0000, in_data_word[47:0]} : in_data_word;

  rsc_syndrome u_syndrome (
    .word (word_in),
    .syn0 (syn0),
    .syn1 (syn1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    op1_r    <= opcode_t'(in_opcode);
    word1_r  <= word_in;
    syn0_1_r <= syn0;
    syn1_1_r <= syn1;
  end

  always_comb begin
    word2_nxt = word1_r;
    if (op1_r == OP_ENC) begin
      word2_nxt[55:48] = gf_mul(syn0_1_r, P6_S0) ^ gf_mul(syn1_1_r, P6_S1);
      word2_nxt[63:56] = gf_mul(syn0_1_r, P7_S0) ^ gf_mul(syn1_1_r, P7_S1);
    end
  end

  always_ff @(posedge clk) begin
    op2_r    <= op1_r;
    word2_r  <= word2_nxt;
    syn0_2_r <= syn0_1_r;
    log0_r   <= GF_LOG[syn0_1_r];
    log1_r   <= GF_LOG[syn1_1_r];
    zero0_r  <= (syn0_1_r == 8'h00);
    zero1_r  <= (syn1_1_r == 8'h00);
  end

  // The error position is log(s1) - log(s0) modulo the field order.
  assign diff    = {1'b0, log1_r} - {1'b0, log0_r};
  assign err_pos = diff[8] ? (diff + 9'(GF_ORDER)) : diff;

  always_comb begin
    case (err_pos[2:0])
      3'd0:    err3_nxt = gf_mul(syn0_2_r, GF_EXP[8'((GF_ORDER - 0) % GF_ORDER)]);
      3'd1:    err3_nxt = gf_mul(syn0_2_r, GF_EXP[8'(GF_ORDER - 1)]);
      3'd2:    err3_nxt = gf_mul(syn0_2_r, GF_EXP[8'(GF_ORDER - 2)]);
      3'd3:    err3_nxt = gf_mul(syn0_2_r, GF_EXP[8'(GF_ORDER - 3)]);
      3'd4:    err3_nxt = gf_mul(syn0_2_r, GF_EXP[8'(GF_ORDER - 4)]);
      3'd5:    err3_nxt = gf_mul(syn0_2_r, GF_EXP[8'(GF_ORDER - 5)]);
      3'd6:    err3_nxt = gf_mul(syn0_2_r, GF_EXP[8'(GF_ORDER - 6)]);
      3'd7:    err3_nxt = gf_mul(syn0_2_r, GF_EXP[8'(GF_ORDER - 7)]);
      default: err3_nxt = syn0_2_r;
    endcase
  end

  always_comb begin
    if (op2_r == OP_ENC) begin
      status3_nxt = ST_CLEAN;
    end else if (zero0_r && zero1_r) begin
      status3_nxt = ST_CLEAN;
    end else if (zero0_r || zero1_r) begin
      status3_nxt = ST_FAIL;
    end else if (err_pos >= 9'(NUM_BYTES)) begin
      status3_nxt = ST_FAIL;
    end else begin
      status3_nxt = ST_FIXED;
    end
  end

  always_ff @(posedge clk) begin
    op3_r     <= op2_r;
    word3_r   <= word2_r;
    status3_r <= status3_nxt;
    err3_r    <= err3_nxt;
    pos3_r    <= err_pos[2:0];
  end

  always_comb begin
    out_word_nxt = word3_r;
    if (status3_r == ST_FIXED) begin
      out_word_nxt[8*pos3_r +: 8] = word3_r[8*pos3_r +: 8] ^ err3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= out_word_nxt;
    out_status_r <= status3_r;
  end

  assign out_valid        = out_valid_r;
  assign out_codeword_out = out_word_r;
  assign out_status       = out_status_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted word did not reach the output after four cycles");

  a_enc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && op3_r == OP_ENC) |=> (out_status == ST_CLEAN))
    else $error("encoded word reported a nonzero status");

  a_fix_changes: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && status3_r == ST_FIXED) |=> (out_codeword_out != $past(word3_r)))
    else $error("corrected word left unchanged");

  a_fail_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && status3_r == ST_FAIL) |=> (out_codeword_out == $past(word3_r)))
    else $error("uncorrectable word was modified");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RS(8,6) GF(256) codec
// Sends encode and decode words through the command port and predicts each
// result with an independent GF(256) encoder and single-byte corrector.
// Every result is compared against the oldest expected word. Directed words
// cover field extremes and each decode outcome. Random traffic then runs in
// phases with different sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
  import rsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [63:0] word;
    status_t     status;
  } codec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_opcode = 1'b0;
  logic [63:0] in_data_word = '0;
  logic        out_valid;
  logic [63:0] out_codeword_out;
  logic [1:0]  out_status;

  codec_result_t expected_words[$];
  int            error_count = 0;

  rs_8_6_gf256_codec i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_data_word     (in_data_word),
    .out_valid        (out_valid),
    .out_codeword_out (out_codeword_out),
    .out_status       (out_status)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- GF(256)

  function automatic gf_t gf_double(input gf_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_RED : 8'h00);
  endfunction

  // Horner product over the bits of y, most significant first.
  function automatic gf_t gf_product(input gf_t x, input gf_t y);
    gf_t acc;
    acc = 8'h00;
    for (int k = 7; k >= 0; k--) begin
      acc = gf_double(acc);
      if (y[k]) acc = acc ^ x;
    end
    return acc;
  endfunction

  function automatic gf_t alpha_pow(input int n);
    gf_t v;
    v = 8'h01;
    repeat (n % GF_ORDER) v = gf_double(v);
    return v;
  endfunction

  // x^254 = x^2 * x^4 * ... * x^128; zero maps to zero.
  function automatic gf_t gf_recip(input gf_t x);
    gf_t sq;
    gf_t r;
    sq = x;
    r = 8'h01;
    for (int k = 1; k < 8; k++) begin
      sq = gf_product(sq, sq);
      r = gf_product(r, sq);
    end
    return r;
  endfunction

  function automatic void syndromes(input logic [63:0] w, input int nbytes,
                                    output gf_t s0, output gf_t s1);
    s0 = 8'h00;
    s1 = 8'h00;
    for (int i = 0; i < nbytes; i++) begin
      s0 = s0 ^ gf_product(w[8*i +: 8], alpha_pow(i));
      s1 = s1 ^ gf_product(w[8*i +: 8], alpha_pow(2 * i));
    end
  endfunction

  function automatic codec_result_t predict_codec(input opcode_t op, input logic [63:0] w);
    codec_result_t res;
    gf_t           s0;
    gf_t           s1;
    gf_t           idet;
    gf_t           p6;
    gf_t           p7;
    gf_t           ratio;
    int            pos;
    res.word = w;
    res.status = ST_CLEAN;
    if (op == OP_ENC) begin
      syndromes(w, NUM_INFO, s0, s1);
      idet = gf_recip(gf_product(alpha_pow(6), alpha_pow(14)) ^
                      gf_product(alpha_pow(7), alpha_pow(12)));
      p6 = gf_product(gf_product(s0, alpha_pow(14)) ^ gf_product(s1, alpha_pow(7)), idet);
      p7 = gf_product(gf_product(s1, alpha_pow(6)) ^ gf_product(s0, alpha_pow(12)), idet);
      res.word = {p7, p6, w[47:0]};
      return res;
    end
    syndromes(w, NUM_BYTES, s0, s1);
    if (s0 == 8'h00 && s1 == 8'h00) return res;
    if (s0 == 8'h00 || s1 == 8'h00) begin
      res.status = ST_FAIL;
      return res;
    end
    ratio = gf_product(s1, gf_recip(s0));
    pos = NUM_BYTES;
    for (int i = NUM_BYTES - 1; i >= 0; i--) begin
      if (alpha_pow(i) == ratio) pos = i;
    end
    if (pos >= NUM_BYTES) begin
      res.status = ST_FAIL;
      return res;
    end
    res.word[8*pos +: 8] = w[8*pos +: 8] ^ gf_product(s0, gf_recip(alpha_pow(pos)));
    res.status = ST_FIXED;
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] encode_info(input logic [63:0] info);
    codec_result_t res;
    res = predict_codec(OP_ENC, info);
    return res.word;
  endfunction

  function automatic logic [63:0] flip_byte(input logic [63:0] w, input int pos,
                                            input gf_t e);
    return w ^ ({56'h0, e} << (8 * pos));
  endfunction

  task automatic report_failure(input string msg);
    if (error_count < MAX_REPORTS) $display("%s", msg);
    error_count++;
  endtask

  // Holds the word until it is taken, then idles at random with start low.
  task automatic send_word(input opcode_t op, input logic [63:0] w, input int idle_pct);
    start <= 1'b1;
    in_opcode <= op;
    in_data_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_opcode <= 1'($urandom);
      in_data_word <= random_word();
      @(posedge clk);
    end
  endtask

  // The expectation is queued before the check so a result that leaves in the
  // same cycle as its word is taken still finds its own word.
  always @(posedge clk) begin
    codec_result_t want;
    if (start === 1'b1 && busy === 1'b0) begin
      expected_words.push_back(predict_codec(opcode_t'(in_opcode), in_data_word));
    end
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (expected_words.size() == 0) begin
        report_failure($sformatf("unexpected word: codeword %h status %0d",
                                 out_codeword_out, out_status));
      end else begin
        want = expected_words.pop_front();
        if (out_codeword_out !== want.word || out_status !== want.status) begin
          report_failure($sformatf("mismatch: codeword %h status %0d, expected %h status %0d",
                                   out_codeword_out, out_status, want.word, want.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_encode_edges();
    send_word(OP_ENC, 64'h0000_0000_0000_0000, 0);
    send_word(OP_ENC, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_word(OP_ENC, 64'h0000_FFFF_FFFF_FFFF, 0);
    send_word(OP_ENC, 64'hFFFF_0000_0000_0000, 0);
    send_word(OP_ENC, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    send_word(OP_ENC, 64'h5555_5555_5555_5555, 0);
  endtask

  task automatic test_decode_cases();
    logic [63:0] cw;
    logic [63:0] w;
    gf_t         e1;
    gf_t         e2;
    gf_t         s0;
    gf_t         s1;
    int          i;
    int          j;
    codec_result_t res;
    send_word(OP_DEC, 64'h0000_0000_0000_0000, 0);
    send_word(OP_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    cw = encode_info(random_word());
    send_word(OP_DEC, cw, 0);
    for (int p = 0; p < NUM_BYTES; p++) begin
      send_word(OP_DEC, flip_byte(cw, p, gf_t'($urandom_range(1, 255))), 0);
    end
    // Two errors whose first syndromes cancel.
    i = $urandom_range(0, 7);
    j = (i + $urandom_range(1, 7)) % NUM_BYTES;
    e1 = gf_t'($urandom_range(1, 255));
    e2 = gf_product(gf_product(e1, alpha_pow(i)), gf_recip(alpha_pow(j)));
    send_word(OP_DEC, flip_byte(flip_byte(cw, i, e1), j, e2), 0);
    // Two errors whose second syndromes cancel.
    e2 = gf_product(gf_product(e1, alpha_pow(2 * i)), gf_recip(alpha_pow(2 * j)));
    send_word(OP_DEC, flip_byte(flip_byte(cw, i, e1), j, e2), 0);
    // Both syndromes nonzero, but the located position lies past the word.
    do begin
      i = $urandom_range(0, 7);
      j = (i + $urandom_range(1, 7)) % NUM_BYTES;
      w = flip_byte(flip_byte(cw, i, gf_t'($urandom_range(1, 255))), j,
                    gf_t'($urandom_range(1, 255)));
      syndromes(w, NUM_BYTES, s0, s1);
      res = predict_codec(OP_DEC, w);
    end while (s0 == 8'h00 || s1 == 8'h00 || res.status != ST_FAIL);
    send_word(OP_DEC, w, 0);
  endtask

  // Encode words, codewords with zero, one or two byte errors (the largest share) and raw noise.
  task automatic test_random_traffic(input int count, input int idle_pct);
    logic [63:0] w;
    int          pick;
    int          i;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_word(OP_ENC, random_word(), idle_pct);
      end else if (pick < 85) begin
        w = encode_info(random_word());
        pick = $urandom_range(99);
        i = $urandom_range(0, 7);
        if (pick >= 25) w = flip_byte(w, i, gf_t'($urandom_range(1, 255)));
        if (pick >= 70) begin
          w = flip_byte(w, (i + $urandom_range(1, 7)) % NUM_BYTES,
                        gf_t'($urandom_range(1, 255)));
        end
        send_word(OP_DEC, w, idle_pct);
      end else begin
        send_word(OP_DEC, random_word(), idle_pct);
      end
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_edges();
    test_decode_cases();
    test_random_traffic(420, 0);
    test_random_traffic(420, 79);
    test_random_traffic(410, 14);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) report_failure("words still expected at the end");
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== rs_8_6_gf256_codec.f =====
rtl/rsc_pkg.sv
rtl/rsc_syndrome.sv
rtl/rs_8_6_gf256_codec.sv
bench/testbench.sv
